// ----- rtl/core/slxfr_pkg.sv -----
// Shared types and constants of the sync/length/XOR frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package slxfr_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam logic [7:0] LEN_CAP = 8'(BUFFER_BYTES - 2);
    localparam logic [7:0] MIN_LENGTH = 8'd5;
    localparam logic [5:0] HEADER_BYTES = 6'd4;

    localparam logic [7:0] SYNC_FIRST_RESET = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;
    localparam logic [5:0] MAX_LENGTH_RESET = 6'd62;

    localparam logic [1:0] CFG_SYNC_FIRST = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_BADSUM = 2'd2;
    localparam logic [1:0] KIND_BADLEN = 2'd3;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_SYNC2,
        ST_LENGTH,
        ST_BODY
    } t_state;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [5:0] max_length;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  command_code;
        logic [7:0]  option_code;
        logic [15:0] transaction_id;
        logic [5:0]  payload_count;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/core/slxfr_if.sv -----
// Channel interfaces of the frame receiver: received bytes, results, configuration.
`timescale 1ns / 1ps
`default_nettype none
interface slxfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slxfr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  command_code;
    logic [7:0]  option_code;
    logic [15:0] transaction_id;
    logic [5:0]  payload_count;
    modport source (output valid, output kind, output data_byte, output command_code,
                    output option_code, output transaction_id, output payload_count,
                    input ready);
    modport sink (input valid, input kind, input data_byte, input command_code,
                  input option_code, input transaction_id, input payload_count,
                  output ready);
endinterface

interface slxfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/slxfr_cfg_regs.sv -----
// Configuration registers of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
module slxfr_cfg_regs (
    input  wire             i_clk,
    input  wire             i_rst_n,
    slxfr_cfg_if.sink       i_cfg,
    output slxfr_pkg::t_cfg o_cfg
);

    slxfr_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first <= slxfr_pkg::SYNC_FIRST_RESET;
            r_cfg.sync_second <= slxfr_pkg::SYNC_SECOND_RESET;
            r_cfg.max_length <= slxfr_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                slxfr_pkg::CFG_SYNC_FIRST: begin
                    r_cfg.sync_first <= i_cfg.data;
                end
                slxfr_pkg::CFG_SYNC_SECOND: begin
                    r_cfg.sync_second <= i_cfg.data;
                end
                slxfr_pkg::CFG_MAX_LENGTH: begin
                    r_cfg.max_length <= i_cfg.data[5:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/slxfr_parser.sv -----
// Input register and frame parse logic of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
module slxfr_parser (
    input  wire                i_clk,
    input  wire                i_rst_n,
    slxfr_rx_if.sink           i_rx,
    input  slxfr_pkg::t_cfg    i_cfg,
    input  wire                i_adv,
    output slxfr_pkg::t_result o_res
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    slxfr_pkg::t_state r_state, n_state;
    logic [5:0]        r_offset, n_offset;
    logic [5:0]        r_length, n_length;
    logic [7:0]        r_xor, n_xor;
    logic [7:0]        r_cmd, n_cmd;
    logic [7:0]        r_opt, n_opt;
    logic [15:0]       r_tid, n_tid;

    logic       fire;
    logic [7:0] limit;
    logic       len_bad;
    logic       last;

    assign i_rx.ready = !r_in_valid || i_adv;
    assign fire = r_in_valid && i_adv;

    assign limit = ({2'b00, i_cfg.max_length} > slxfr_pkg::LEN_CAP) ?
                   slxfr_pkg::LEN_CAP : {2'b00, i_cfg.max_length};
    assign len_bad = (r_in_byte < slxfr_pkg::MIN_LENGTH) || (r_in_byte > limit);
    assign last = !(({1'b0, r_offset} + 7'd1) < {1'b0, r_length});

    // hold the request until the parse stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (i_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_comb begin
        n_state = r_state;
        n_offset = r_offset;
        n_length = r_length;
        n_xor = r_xor;
        n_cmd = r_cmd;
        n_opt = r_opt;
        n_tid = r_tid;
        if (fire) begin
            case (r_state)
                slxfr_pkg::ST_HUNT: begin
                    if (r_in_byte == i_cfg.sync_first) begin
                        n_state = slxfr_pkg::ST_SYNC2;
                    end
                end
                slxfr_pkg::ST_SYNC2: begin
                    n_state = (r_in_byte == i_cfg.sync_second) ?
                              slxfr_pkg::ST_LENGTH : slxfr_pkg::ST_HUNT;
                end
                slxfr_pkg::ST_LENGTH: begin
                    if (len_bad) begin
                        n_state = slxfr_pkg::ST_HUNT;
                    end else begin
                        n_state = slxfr_pkg::ST_BODY;
                        n_length = r_in_byte[5:0];
                        n_offset = 6'd0;
                        n_xor = 8'd0;
                        n_cmd = 8'd0;
                        n_opt = 8'd0;
                        n_tid = 16'd0;
                    end
                end
                slxfr_pkg::ST_BODY: begin
                    if (last) begin
                        n_state = slxfr_pkg::ST_HUNT;
                    end else begin
                        n_xor = r_xor ^ r_in_byte;
                        n_offset = r_offset + 6'd1;
                        case (r_offset)
                            6'd0: n_cmd = r_in_byte;
                            6'd1: n_opt = r_in_byte;
                            6'd2: n_tid = {r_in_byte, r_tid[7:0]};
                            6'd3: n_tid = {r_tid[15:8], r_in_byte};
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                    n_state = slxfr_pkg::ST_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        o_res = '0;
        case (r_state)
            slxfr_pkg::ST_LENGTH: begin
                o_res.valid = fire && len_bad;
                o_res.kind = slxfr_pkg::KIND_BADLEN;
            end
            slxfr_pkg::ST_BODY: begin
                o_res.command_code = r_cmd;
                o_res.option_code = r_opt;
                o_res.transaction_id = r_tid;
                if (last) begin
                    o_res.valid = fire;
                    o_res.kind = (r_xor == r_in_byte) ?
                                 slxfr_pkg::KIND_GOOD : slxfr_pkg::KIND_BADSUM;
                    o_res.payload_count = r_length - slxfr_pkg::MIN_LENGTH[5:0];
                end else begin
                    o_res.valid = fire && (r_offset >= slxfr_pkg::HEADER_BYTES);
                    o_res.kind = slxfr_pkg::KIND_PAYLOAD;
                    o_res.data_byte = r_in_byte;
                    o_res.payload_count = r_offset - slxfr_pkg::HEADER_BYTES;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slxfr_pkg::ST_HUNT;
            r_offset <= 6'd0;
            r_length <= 6'd0;
            r_xor <= 8'd0;
            r_cmd <= 8'd0;
            r_opt <= 8'd0;
            r_tid <= 16'd0;
        end else begin
            r_state <= n_state;
            r_offset <= n_offset;
            r_length <= n_length;
            r_xor <= n_xor;
            r_cmd <= n_cmd;
            r_opt <= n_opt;
            r_tid <= n_tid;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/slxfr_out_reg.sv -----
// Result register of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
module slxfr_out_reg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  slxfr_pkg::t_result i_res,
    output logic               o_adv,
    slxfr_res_if.source        o_res
);

    logic               r_valid;
    slxfr_pkg::t_result r_res;

    assign o_adv = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_res.valid;
        end
    end

    // advance the payload only when a new result lands
    always_ff @(posedge i_clk) begin
        if (o_adv && i_res.valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid = r_valid;
    assign o_res.kind = r_res.kind;
    assign o_res.data_byte = r_res.data_byte;
    assign o_res.command_code = r_res.command_code;
    assign o_res.option_code = r_res.option_code;
    assign o_res.transaction_id = r_res.transaction_id;
    assign o_res.payload_count = r_res.payload_count;

endmodule
`default_nettype wire

// ----- rtl/core/sync_length_xor_frame_receiver_unit.sv -----
// Top level of the two-sync, length-prefixed frame receiver with XOR checksum.
//
// Channels: i_rx takes one received byte per request; o_res gives zero or one
// result per byte (payload byte, frame good, checksum bad, length rejected)
// with the frame's command, option, transaction id and payload count.
// i_cfg writes sync_first (0), sync_second (1) and max_length (2); other
// indexes are dropped. Write configuration only while the block is idle.
// Throughput: one byte per cycle, sustained while o_res takes its results, set by the single parse stage.
// Path: a byte accepted into the input register goes through the parse logic
// into the result register.
// Stall: while a result waits on o_res the parser holds; i_rx still takes one
// more byte into the input register, then drops ready until the result goes.
// Reset: i_rst_n low at a clock edge returns the parser to hunting for the
// first sync byte, clears both registers' valid flags and restores the
// configuration to 0xAA, 0x55 and 62.
`timescale 1ns / 1ps
`default_nettype none
module sync_length_xor_frame_receiver_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    slxfr_rx_if.sink     i_rx,
    slxfr_cfg_if.sink    i_cfg,
    slxfr_res_if.source  o_res
);

    slxfr_pkg::t_cfg    cfg;
    slxfr_pkg::t_result parse_res;
    logic               adv;

    slxfr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    slxfr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (cfg),
        .i_adv   (adv),
        .o_res   (parse_res)
    );

    slxfr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (parse_res),
        .o_adv   (adv),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
